/* rtl/core/bbc_pkg.sv */
// bbc_pkg: shared types and constants of the bracket balance checker
// no dependencies; used by the interfaces, front, back and top level
package bbc_pkg;

  localparam int unsigned StackDepthDefault = 128;
  localparam int unsigned CharW    = 8;
  localparam int unsigned VerdictW = 3;

  // bracket characters
  localparam logic [CharW-1:0] CharOpenRound   = 8'h28;
  localparam logic [CharW-1:0] CharOpenSquare  = 8'h5B;
  localparam logic [CharW-1:0] CharOpenCurly   = 8'h7B;
  localparam logic [CharW-1:0] CharCloseRound  = 8'h29;
  localparam logic [CharW-1:0] CharCloseSquare = 8'h5D;
  localparam logic [CharW-1:0] CharCloseCurly  = 8'h7D;

  typedef enum logic [VerdictW-1:0] {
    VerdictOk        = 3'd0,
    VerdictMismatch  = 3'd1,
    VerdictRightMore = 3'd2,
    VerdictLeftMore  = 3'd3,
    VerdictCorrect   = 3'd4,
    VerdictOverflow  = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    KindRound  = 2'd0,
    KindSquare = 2'd1,
    KindCurly  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OpNone  = 2'd0,
    OpOpen  = 2'd1,
    OpClose = 2'd2
  } op_e;

  // classified character as it travels from front to back
  typedef struct packed {
    op_e   op;
    kind_e kind;
    logic  last;
  } op_item_t;

endpackage

/* rtl/core/bbc_in_if.sv */
// bbc_in_if: valid/ready channel carrying one text character per transaction
// depends on bbc_pkg for field widths
interface bbc_in_if;
  import bbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

/* rtl/core/bbc_out_if.sv */
// bbc_out_if: valid/ready channel carrying one verdict per transaction
// depends on bbc_pkg for field widths
interface bbc_out_if;
  import bbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [VerdictW-1:0] verdict;
  logic                final_verdict;

  modport source (output valid, output verdict, output final_verdict, input ready);
  modport sink   (input valid, input verdict, input final_verdict, output ready);
endinterface

/* rtl/core/bbc_front.sv */
// bbc_front: accepts characters, decodes them into open/close/ignore ops
// and buffers them in a two-entry queue; depends on bbc_pkg, bbc_in_if
module bbc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  bbc_in_if.sink             in_i,
  output bbc_pkg::op_item_t  item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);
  import bbc_pkg::*;

  localparam int unsigned QueueDepth = 2;

  op_item_t   entry_q [QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  op_item_t   decoded;
  logic       push, pop;

  // character decoder
  always_comb begin
    decoded.op   = OpNone;
    decoded.kind = KindRound;
    decoded.last = in_i.last_char;
    unique case (in_i.character)
      CharOpenRound:   begin decoded.op = OpOpen;  decoded.kind = KindRound;  end
      CharOpenSquare:  begin decoded.op = OpOpen;  decoded.kind = KindSquare; end
      CharOpenCurly:   begin decoded.op = OpOpen;  decoded.kind = KindCurly;  end
      CharCloseRound:  begin decoded.op = OpClose; decoded.kind = KindRound;  end
      CharCloseSquare: begin decoded.op = OpClose; decoded.kind = KindSquare; end
      CharCloseCurly:  begin decoded.op = OpClose; decoded.kind = KindCurly;  end
      default: ;
    endcase
  end

  assign in_i.ready   = (count_q != 2'(QueueDepth));
  assign push         = in_i.valid && in_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= decoded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QueueDepth))
    else $error("queue count beyond depth");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not follow a lone push");

endmodule

/* rtl/core/bbc_back.sv */
// bbc_back: bracket stack with cached top and prefetched next entry,
// error latch and output register; depends on bbc_pkg, bbc_out_if
module bbc_back #(
  parameter int unsigned StackDepth = bbc_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbc_pkg::op_item_t  item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  bbc_out_if.source          out_o
);
  import bbc_pkg::*;

  localparam int unsigned DW = $clog2(StackDepth + 1);
  localparam int unsigned AW = $clog2(StackDepth);

  // entries below the top; the top itself lives in top_q
  kind_e          mem [StackDepth];
  kind_e          top_q, top_d;
  kind_e          rd_q;
  logic [DW-1:0]  depth_q, depth_d;
  verdict_e       err_q, err_d;
  logic           out_valid_q;
  verdict_e       out_verdict_q, verdict_d;
  logic           out_final_q;
  logic           exec, we;
  logic [AW-1:0]  waddr, raddr;

  assign item_ready_o = !out_valid_q || out_o.ready;
  assign exec         = item_valid_i && item_ready_o;

  always_comb begin
    err_d     = err_q;
    depth_d   = depth_q;
    top_d     = top_q;
    we        = 1'b0;
    verdict_d = err_q;
    if (exec) begin
      if (err_q == VerdictOk) begin
        case (item_i.op)
          OpOpen: begin
            if (depth_q == DW'(StackDepth)) begin
              err_d = VerdictOverflow;
            end else begin
              we      = (depth_q != '0);
              top_d   = item_i.kind;
              depth_d = depth_q + DW'(1);
            end
          end
          OpClose: begin
            if (depth_q == '0) begin
              err_d = VerdictRightMore;
            end else if (top_q == item_i.kind) begin
              top_d   = rd_q;
              depth_d = depth_q - DW'(1);
            end else begin
              err_d = VerdictMismatch;
            end
          end
          default: ;
        endcase
      end
      if (item_i.last) begin
        if (err_d != VerdictOk)     verdict_d = err_d;
        else if (depth_d != '0)     verdict_d = VerdictLeftMore;
        else                        verdict_d = VerdictCorrect;
        err_d   = VerdictOk;
        depth_d = '0;
      end else begin
        verdict_d = err_d;
      end
    end
  end

  // old top moves into memory on push; prefetch the entry under the new top
  assign waddr = AW'(depth_q - DW'(1));
  assign raddr = AW'(depth_d - DW'(2));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= top_q;
    end
    if (we && (waddr == raddr)) begin
      rd_q <= top_q;
    end else begin
      rd_q <= mem[raddr];
    end
    top_q <= top_d;
    if (exec) begin
      out_verdict_q <= verdict_d;
      out_final_q   <= item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      err_q       <= VerdictOk;
      out_valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      err_q   <= err_d;
      if (exec)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.verdict       = out_verdict_q;
  assign out_o.final_verdict = out_final_q;

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(StackDepth))
    else $error("stack depth beyond capacity");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && item_i.last) |=> (depth_q == '0 && err_q == VerdictOk))
    else $error("state not cleared after last character");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != VerdictOk && !(exec && item_i.last)) |=> (err_q == $past(err_q)))
    else $error("latched error changed inside an expression");

  a_pending_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_final_q) |->
      (out_verdict_q != VerdictLeftMore && out_verdict_q != VerdictCorrect))
    else $error("final-only verdict on a pending result");

endmodule

/* rtl/core/bracket_balance_checker_top.sv */
// bracket_balance_checker_top: top level of the bracket balance checker
// depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_front, bbc_back
//
// usage
// - in_i carries one text byte (character) per transaction, with last_char
//   set on the final byte of an expression
// - out_o returns exactly one transaction per input byte, in order: verdict
//   is the first latched error (or ok) with final_verdict low, and on the
//   last byte the verdict for the whole expression with final_verdict high
// - round, square and curly brackets are tracked on a stack of StackDepth
//   entries; an open bracket on a full stack reports overflow
// pipeline and throughput
// - a result is held in the queue and then in the output register, where
//   it stays valid until the receiver takes it
// - one byte per cycle while the receiver holds ready high; the stack top
//   is cached in a register and the entry below it is prefetched from the
//   stack memory, so no push or pop stalls the back end
// stalls
// - a two-entry queue sits between the decoder and the stack engine; when
//   the receiver holds ready low the output register holds its result, the
//   queue fills and in_i.ready drops once both entries are taken
// reset
// - rst_ni clears the stack depth, the error latch, the queue and the output
//   valid; the stack memory is not cleared and needs no clearing pass
module bracket_balance_checker_top #(
  parameter int unsigned StackDepth = bbc_pkg::StackDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_in_if.sink    in_i,
  bbc_out_if.source out_o
);
  import bbc_pkg::*;

  // decoded byte handed from the front end to the stack engine
  op_item_t item;
  logic     item_valid;
  logic     item_ready;

  // front end: byte decoder and queue
  bbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // back end: stack, error latch and output register
  bbc_back #(
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule
